// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and constants shared by the DNS message classifier.
// ----------------------------------------------------------------------------
package dmc_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] packet_byte;
    logic       last_byte;
  } dmc_in_t;

  typedef struct packed {
    logic        header_ok;
    logic [3:0]  dns_opcode;
    logic [3:0]  rcode;
    logic [15:0] question_type;
    logic [5:0]  flag_bits;
    logic [15:0] question_total;
    logic [15:0] answer_total;
    logic [15:0] authority_total;
    logic [15:0] additional_total;
    logic [15:0] message_id;
    logic [2:0]  match_status;
    logic        resp_good;
  } dmc_out_t;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_MATCHED = 3'd1;
  localparam logic [2:0] ST_CACHE   = 3'd2;
  localparam logic [2:0] ST_UPSTRM  = 3'd3;
  localparam logic [2:0] ST_TRACKED = 3'd4;

  localparam logic [1:0] PH_SCAN  = 2'd0;
  localparam logic [1:0] PH_FOUND = 2'd1;
  localparam logic [1:0] PH_FAIL  = 2'd2;

  localparam int HDR_BYTES = 12;

endpackage

// ===== rtl/dns_message_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// dns_message_classifier_unit
// DNS header and first-question parser with a query history.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input is not stalled. After the last
// byte of a query with a full header the input stalls while the history is
// written. After the last byte of a response with a full header the input
// stalls while the history RAM is scanned one entry per cycle, until a hit or
// the end of the history. A last byte is also held off while the previous
// result waits in the output register; the other bytes of the next packet
// are taken meanwhile.
module dns_message_classifier_unit #(
  parameter int HISTORY_DEPTH    = 256,
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dmc_pkg::dmc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dmc_pkg::dmc_out_t out_data
);
  import dmc_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = $clog2(MAX_PACKET_BYTES + 65);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r;
  logic [PW-1:0] pos_r, nlp_r, tpos_r;
  logic [1:0]    phase_r;
  logic [15:0]   hw_r [6];
  logic [15:0]   ctype_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] old_r;
  logic [CW-1:0] idx_r;
  logic          rd_pend_r, hit_r;
  dmc_out_t      res_r;
  logic          ovalid_r;

  logic [15:0] fl, id, qt;
  logic [PW-1:0] len;
  logic          take, fin, do_track;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [15:0]   rid, rty;
  logic [AW:0]   sum;
  logic [AW:0]   sum_w;

  function automatic logic mult3(logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 5'(v[2*i +: 2]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
  endfunction

  assign take = in_valid && !in_stall;
  assign in_stall = (state_r != S_RUN) || (in_data.last_byte && ovalid_r);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  // state after this byte (byte taken if under limit)
  logic [15:0]   hw_nxt [6];
  logic [PW-1:0] pos_nxt, nlp_nxt, tpos_nxt;
  logic [1:0]    ph_nxt;
  logic [15:0]   ct_nxt;
  logic [7:0]    b;
  always_comb begin
    b = in_data.packet_byte;
    for (int i = 0; i < 6; i++) hw_nxt[i] = hw_r[i];
    pos_nxt = pos_r; nlp_nxt = nlp_r; tpos_nxt = tpos_r; ph_nxt = phase_r; ct_nxt = ctype_r;
    if (pos_r < PW'(MAX_PACKET_BYTES)) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r < PW'(HDR_BYTES)) begin
        if (!pos_r[0]) hw_nxt[pos_r[3:1]] = {b, 8'h00};
        else hw_nxt[pos_r[3:1]] = hw_r[pos_r[3:1]] | {8'h00, b};
      end else if (phase_r == PH_SCAN) begin
        if (pos_r == nlp_r) begin
          if (b == 8'h00) begin
            tpos_nxt = pos_r + 1'b1; ph_nxt = PH_FOUND;
          end else if ((b & 8'hC0) == 8'hC0) begin
            tpos_nxt = pos_r + PW'(2); ph_nxt = PH_FOUND;
          end else if ((b & 8'hC0) == 8'h00) begin
            nlp_nxt = pos_r + 1'b1 + PW'(b);
          end else begin
            ph_nxt = PH_FAIL;
          end
        end
      end else if (phase_r == PH_FOUND) begin
        if (pos_r == tpos_r) ct_nxt = {b, 8'h00};
        else if (pos_r == tpos_r + 1'b1) ct_nxt = ctype_r | {8'h00, b};
      end
    end
  end

  assign fl  = hw_nxt[1];
  assign id  = hw_nxt[0];
  assign len = pos_nxt;
  assign qt  = (hw_nxt[2] != 16'd0 && ph_nxt == PH_FOUND && (tpos_nxt + PW'(4)) <= len)
               ? ct_nxt : 16'd0;
  assign fin = take && in_data.last_byte;
  assign do_track = fin && (len >= PW'(HDR_BYTES)) && !in_data.opcode;

  assign sum = {1'b0, old_r} + (AW + 1)'(idx_r);
  always_comb begin
    sum_w = sum;
    if (do_track) begin
      if (cnt_r >= CW'(HISTORY_DEPTH)) ram_addr = old_r;
      else begin
        sum_w = {1'b0, old_r} + (AW + 1)'(cnt_r);
        ram_addr = (sum_w >= (AW + 1)'(HISTORY_DEPTH)) ?
                   AW'(sum_w - (AW + 1)'(HISTORY_DEPTH)) : AW'(sum_w);
      end
    end else begin
      ram_addr = (sum >= (AW + 1)'(HISTORY_DEPTH)) ?
                 AW'(sum - (AW + 1)'(HISTORY_DEPTH)) : AW'(sum);
    end
  end
  assign ram_we = do_track;

  dmc_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH)) u_ids (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(id), .rdata(rid));
  dmc_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH)) u_types (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(qt), .rdata(rty));

  dmc_out_t pend_r;
  logic [15:0] key_id_r, key_qt_r;
  dmc_out_t base;
  logic [5:0] fb;
  always_comb begin
    fb = {fl[10], fl[9], fl[8], fl[7], fl[5], fl[4]};
    base = '0;
    if (len >= PW'(HDR_BYTES)) begin
      base.header_ok = 1'b1;
      base.dns_opcode = fl[14:11];
      base.rcode = fl[3:0];
      base.question_type = qt;
      base.flag_bits = fb;
      base.question_total = hw_nxt[2];
      base.answer_total = hw_nxt[3];
      base.authority_total = hw_nxt[4];
      base.additional_total = hw_nxt[5];
      base.message_id = id;
      base.match_status = in_data.opcode ? ST_NONE : ST_TRACKED;
      base.resp_good = in_data.opcode && (fl[3:0] == 4'd0 || fl[3:0] == 4'd3);
    end
  end

  logic hit_now, scan_end;
  assign hit_now = rd_pend_r && rid == key_id_r && rty == key_qt_r;
  assign scan_end = (idx_r >= cnt_r) && !rd_pend_r;

  dmc_out_t scan_res;
  always_comb begin
    scan_res = pend_r;
    if (hit_r || hit_now) begin
      if (pend_r.answer_total != 16'd0 && pend_r.rcode == 4'd0)
        scan_res.match_status = mult3(pend_r.message_id) ? ST_CACHE : ST_UPSTRM;
      else scan_res.match_status = ST_MATCHED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN; pos_r <= '0; nlp_r <= PW'(HDR_BYTES); tpos_r <= '0;
      phase_r <= PH_SCAN; ctype_r <= '0; cnt_r <= '0; old_r <= '0; idx_r <= '0;
      rd_pend_r <= 1'b0; hit_r <= 1'b0; ovalid_r <= 1'b0;
      for (int i = 0; i < 6; i++) hw_r[i] <= '0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (take) begin
        if (in_data.last_byte) begin
          pos_r <= '0; nlp_r <= PW'(HDR_BYTES); tpos_r <= '0; phase_r <= PH_SCAN;
          ctype_r <= '0;
          for (int i = 0; i < 6; i++) hw_r[i] <= '0;
          if (base.header_ok && in_data.opcode) begin
            pend_r <= base; key_id_r <= id; key_qt_r <= qt;
            idx_r <= '0; rd_pend_r <= 1'b0; hit_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            res_r <= base; ovalid_r <= 1'b1;
            if (do_track) begin
              if (cnt_r >= CW'(HISTORY_DEPTH)) begin
                old_r <= (old_r == AW'(HISTORY_DEPTH - 1)) ? '0 : old_r + 1'b1;
              end else cnt_r <= cnt_r + 1'b1;
              state_r <= S_DONE;
            end
          end
        end else begin
          pos_r <= pos_nxt; nlp_r <= nlp_nxt; tpos_r <= tpos_nxt; phase_r <= ph_nxt;
          ctype_r <= ct_nxt;
          for (int i = 0; i < 6; i++) hw_r[i] <= hw_nxt[i];
        end
      end
      if (state_r == S_DONE) state_r <= S_RUN;
      if (state_r == S_SCAN) begin
        if (hit_now) hit_r <= 1'b1;
        if (idx_r < cnt_r && !(hit_r || hit_now)) begin
          idx_r <= idx_r + 1'b1; rd_pend_r <= 1'b1;
        end else rd_pend_r <= 1'b0;
        if (((hit_r || hit_now) || scan_end) && !ovalid_r) begin
          res_r <= scan_res;
          ovalid_r <= 1'b1; state_r <= S_RUN;
        end
      end
    end
  end
endmodule

// ===== rtl/dmc_ram.sv =====
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/dmc_checker.sv =====
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks for the DNS message classifier.
// ----------------------------------------------------------------------------
module dmc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input dmc_pkg::dmc_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input dmc_pkg::dmc_out_t out_data
);
  import dmc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.header_ok |-> out_data.match_status == ST_NONE &&
    out_data.message_id == 16'd0)
    else $error("short packet result not zero");
  a_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_status == ST_TRACKED |-> !out_data.resp_good)
    else $error("tracked query marked as response");
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_valid && in_data.last_byte |-> in_stall)
    else $error("last byte taken while a result waits");
endmodule

bind dns_message_classifier_unit dmc_checker u_dmc_checker (.*);

// ===== verif/tb_dns_message_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dns_message_classifier_unit
// Drives DNS messages byte by byte into the classifier, predicts each
// per-message result with a behavioral parser and query history, and checks
// every result transfer field by field. A directed table runs first, then
// random well-formed and broken messages under several idle/stall phases.
// ----------------------------------------------------------------------------
module tb_dns_message_classifier_unit;
  import dmc_pkg::*;

  localparam int HIST_DEPTH = 4;
  localparam int MAX_BYTES  = 32;

  typedef logic [7:0] byte_q_t[$];

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  dmc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dmc_out_t out_data;

  dns_message_classifier_unit #(
    .HISTORY_DEPTH(HIST_DEPTH), .MAX_PACKET_BYTES(MAX_BYTES)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // predictor state
  logic [15:0] hist_id [HIST_DEPTH];
  logic [15:0] hist_qt [HIST_DEPTH];
  int          hist_cnt;
  int          hist_old;
  int          msg_pos;
  logic [15:0] hdr [6];
  int          label_pos;
  logic [1:0]  phase;
  int          qt_pos;
  logic [15:0] qt_cap;

  dmc_out_t    expected_results[$];
  int          errors = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_active = 1'b0;
  event        hold_go;

  function automatic void clear_msg();
    msg_pos = 0;
    for (int i = 0; i < 6; i++) hdr[i] = '0;
    label_pos = HDR_BYTES;
    phase = PH_SCAN;
    qt_pos = 0;
    qt_cap = '0;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int p;
    p = msg_pos;
    if (p < HDR_BYTES) begin
      if (p % 2 == 0) hdr[p/2] = {b, 8'h00};
      else hdr[p/2][7:0] = b;
    end else if (phase == PH_SCAN) begin
      if (p == label_pos) begin
        if (b == 8'h00) begin
          qt_pos = p + 1; phase = PH_FOUND;
        end else if (b[7:6] == 2'b11) begin
          qt_pos = p + 2; phase = PH_FOUND;
        end else if (b[7:6] == 2'b00) begin
          label_pos = p + 1 + b;
        end else begin
          phase = PH_FAIL;
        end
      end
    end else if (phase == PH_FOUND) begin
      if (p == qt_pos) qt_cap = {b, 8'h00};
      else if (p == qt_pos + 1) qt_cap[7:0] = b;
    end
  endfunction

  function automatic bit history_has(logic [15:0] id, logic [15:0] qt);
    for (int i = 0; i < hist_cnt; i++) begin
      int s;
      s = (hist_old + i) % HIST_DEPTH;
      if (hist_id[s] == id && hist_qt[s] == qt) return 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 when the item closes a message, with its classification
  function automatic bit classify_byte(dmc_in_t it, output dmc_out_t r);
    logic [15:0] fl, qt;
    logic [3:0]  rc;
    int          slot;
    r = '0;
    if (msg_pos < MAX_BYTES) begin
      parse_byte(it.packet_byte);
      msg_pos++;
    end
    if (!it.last_byte) return 1'b0;
    if (msg_pos >= HDR_BYTES) begin
      fl = hdr[1];
      rc = fl[3:0];
      qt = '0;
      if (hdr[2] != 0 && phase == PH_FOUND && qt_pos + 4 <= msg_pos) qt = qt_cap;
      r.header_ok        = 1'b1;
      r.dns_opcode       = fl[14:11];
      r.rcode            = rc;
      r.question_type    = qt;
      r.flag_bits        = {fl[10], fl[9], fl[8], fl[7], fl[5], fl[4]};
      r.question_total   = hdr[2];
      r.answer_total     = hdr[3];
      r.authority_total  = hdr[4];
      r.additional_total = hdr[5];
      r.message_id       = hdr[0];
      if (!it.opcode) begin
        if (hist_cnt >= HIST_DEPTH) begin
          slot = hist_old;
          hist_old = (hist_old + 1) % HIST_DEPTH;
        end else begin
          slot = (hist_old + hist_cnt) % HIST_DEPTH;
          hist_cnt++;
        end
        hist_id[slot] = hdr[0];
        hist_qt[slot] = qt;
        r.match_status = ST_TRACKED;
      end else if (history_has(hdr[0], qt)) begin
        if (hdr[3] != 0 && rc == 4'd0)
          r.match_status = (hdr[0] % 3 == 0) ? ST_CACHE : ST_UPSTRM;
        else
          r.match_status = ST_MATCHED;
      end else begin
        r.match_status = ST_NONE;
      end
      r.resp_good = it.opcode && (rc == 4'd0 || rc == 4'd3);
    end
    clear_msg();
    return 1'b1;
  endfunction

  task automatic send_item(dmc_in_t it, bit use_fx, dmc_out_t fx);
    dmc_out_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (classify_byte(it, r)) expected_results.push_back(use_fx ? fx : r);
  endtask

  // opcode only counts on the last byte
  task automatic send_message(byte_q_t m, logic dir, bit use_fx, dmc_out_t fx);
    dmc_in_t it;
    foreach (m[i]) begin
      it.opcode      = (i == m.size() - 1) ? dir : 1'($urandom_range(1));
      it.packet_byte = m[i];
      it.last_byte   = (i == m.size() - 1);
      send_item(it, use_fx, fx);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_q_t make_header(logic [15:0] id, logic [15:0] fl,
                                          logic [15:0] qd, logic [15:0] an);
    byte_q_t q;
    q = {id[15:8], id[7:0], fl[15:8], fl[7:0], qd[15:8], qd[7:0], an[15:8], an[7:0],
         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    return q;
  endfunction

  // well-formed query/response with random labels; when broken, noise, or a bad label and a cut tail
  function automatic byte_q_t make_message(logic [15:0] id, logic [15:0] qt, bit broken);
    byte_q_t q;
    logic [15:0] fl;
    int n;
    if (broken && $urandom_range(2) == 0) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
      return q;
    end
    fl = 16'($urandom);
    if ($urandom_range(1)) fl[3:0] = 4'd0;
    q = make_header(id, fl, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)));
    n = $urandom_range(0, 2);
    for (int l = 0; l < n; l++) begin
      int len;
      len = $urandom_range(1, 4);
      q.push_back(8'(len));
      for (int i = 0; i < len; i++) q.push_back(8'($urandom));
    end
    case ($urandom_range(3))
      0: q.push_back(8'h00);
      1: begin q.push_back(8'hC0 | 8'($urandom_range(63))); q.push_back(8'($urandom)); end
      2: q.push_back(8'h00);
      default: q.push_back(broken ? 8'h40 | 8'($urandom_range(127)) : 8'h00);
    endcase
    q.push_back(qt[15:8]);
    q.push_back(qt[7:0]);
    q.push_back(8'h00);
    q.push_back(8'h01);
    if (broken) begin
      n = $urandom_range(1, 5);
      repeat (n) void'(q.pop_back());
    end
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
    return q;
  endfunction

  // long receiver hold-off, counted here
  initial begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          dmc_out_t e;
          e = expected_results.pop_front();
          if (out_data.header_ok != e.header_ok ||
              out_data.dns_opcode != e.dns_opcode ||
              out_data.rcode != e.rcode ||
              out_data.question_type != e.question_type ||
              out_data.flag_bits != e.flag_bits ||
              out_data.question_total != e.question_total ||
              out_data.answer_total != e.answer_total ||
              out_data.authority_total != e.authority_total ||
              out_data.additional_total != e.additional_total ||
              out_data.message_id != e.message_id ||
              out_data.match_status != e.match_status ||
              out_data.resp_good != e.resp_good) begin
            $display("%0t: expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      out_stall <= hold_active ||
                   ((recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct));
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    byte_q_t  m;
    dmc_out_t fixed;
    logic [15:0] ids[$];
    logic [15:0] qts[$];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hist_cnt = 0;
    hist_old = 0;
    clear_msg();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short messages, extremes, label cases, matches
    begin
      byte_q_t rows[$];
      logic    dirs[$];
      rows.push_back({8'hFF});
      rows.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00});
      rows.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF});
      rows.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00});
      rows.push_back({8'h12, 8'h33, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h03, 8'h61, 8'h62, 8'h63, 8'h00, 8'h00, 8'h1C,
                      8'h00, 8'h01});
      rows.push_back({8'h12, 8'h33, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h03, 8'h61, 8'h62, 8'h63, 8'h00, 8'h00, 8'h1C,
                      8'h00, 8'h01});
      rows.push_back({8'h12, 8'h33, 8'h81, 8'h83, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'hC0, 8'h0C, 8'h00, 8'h1C, 8'h00, 8'h01});
      rows.push_back({8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01});
      rows.push_back({8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01});
      rows.push_back({8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h41, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01});
      rows.push_back({8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h81, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01});
      rows.push_back({8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00});
      rows.push_back({8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01});
      dirs = {1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
      foreach (rows[i]) begin
        // short messages give all zero; all-ones and all-zero headers typed in
        fixed = '0;
        if (i == 2) begin
          fixed.header_ok        = 1'b1;
          fixed.dns_opcode       = 4'hF;
          fixed.rcode            = 4'hF;
          fixed.flag_bits        = 6'h3F;
          fixed.question_total   = 16'hFFFF;
          fixed.answer_total     = 16'hFFFF;
          fixed.authority_total  = 16'hFFFF;
          fixed.additional_total = 16'hFFFF;
          fixed.message_id       = 16'hFFFF;
          fixed.match_status     = ST_NONE;
        end else if (i == 3) begin
          fixed.header_ok = 1'b1;
          fixed.resp_good = 1'b1;
        end
        send_message(rows[i], dirs[i], i < 4, fixed);
        drain();
      end
    end

    // oversize message: bytes past the byte limit are dropped
    fixed = '0;
    m = make_message(16'h0006, 16'h0001, 1'b0);
    while (m.size() < MAX_BYTES + 8) m.insert(m.size() - 1, 8'($urandom));
    send_message(m, 1'b0, 1'b0, fixed);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 2) -> hold_go;
      for (int k = 0; k < 4; k++) begin
        logic [15:0] id, qt;
        bit dir, broken;
        dir = $urandom_range(1);
        broken = ($urandom_range(4) == 0);
        if (dir && ids.size() != 0 && $urandom_range(3) != 0) begin
          int j;
          j = $urandom_range(ids.size() - 1);
          id = ids[j]; qt = qts[j];
        end else begin
          id = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
          qt = 16'($urandom);
        end
        if (!dir) begin
          ids.push_back(id); qts.push_back(qt);
          if (ids.size() > 300) begin void'(ids.pop_front()); void'(qts.pop_front()); end
        end
        m = make_message(id, qt, broken);
        send_message(m, dir, 1'b0, fixed);
      end
      drain();
    end

    repeat (20) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/dns_message_classifier_unit.sv
rtl/dmc_checker.sv
verif/tb_dns_message_classifier_unit.sv
